// ===== hdl/first_fit_page_run_allocator_top_macros.svh =====
// Assertion macros for the page run allocator.
// Included by the modules that check their own control logic.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_CLK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_CLK_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/ffpra_pkg.sv =====
// Shared types and constants for the page run allocator.
// Used by the controller, the datapath and the top level.
package ffpra_pkg;

  localparam int PAGE_SHIFT = 12;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOROOM = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_USED = 2'd1,
    MARK_END  = 2'd2
  } mark_t;

  typedef struct packed {
    logic    clr;       // write free at walk index, advance
    logic    load;      // capture request beat
    logic    begin_op;  // set up walk for the captured request
    logic    scan;      // read and count free pages
    logic    mark;      // write used/end over the found run
    logic    free;      // read and clear up to the end tag or the table end
    logic    res_set;   // latch the result
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic kind;
    logic hit;
    logic miss;
    logic mark_last;
    logic free_stop;
  } dp_stat_t;

endpackage

// ===== hdl/first_fit_page_run_allocator_top.sv =====
// Allocate: after the accept and check steps, a scan page by page through the run end (through the
// whole table on a miss), a marking pass over the run on a hit, then the done cycle.
// Free: accept and check steps, then a pass that clears pages through the next end tag or the table end.
// Bad request: done follows the check step. One request at a time; busy high throughout,
// and the next request is taken at the edge that ends the done cycle.
// After reset a clearing pass over every page holds busy high; the receiver cannot stall.
module first_fit_page_run_allocator_top #(
  parameter int NUM_PAGES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [13:0] page_count,
  input  logic [31:0] address,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] run_address,
  output logic [12:0] start_page
);
  import ffpra_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffpra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ffpra_dpath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .page_count  (page_count),
    .address     (address),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .run_address (run_address),
    .start_page  (start_page)
  );

endmodule

// ===== hdl/ffpra_ctrl.sv =====
// Controller state machine for the page run allocator.
// Depends on ffpra_pkg; drives the datapath by command struct.
`include "first_fit_page_run_allocator_top_macros.svh"

module ffpra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffpra_pkg::dp_stat_t stat,
  output ffpra_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import ffpra_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_FREE
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BAD;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.begin_op = 1'b1;
          state_next   = (stat.kind == KIND_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = S_MARK;
        end else if (stat.miss) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOROOM;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.mark_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FREE: begin
        cmd.free = 1'b1;
        if (stat.free_stop) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  `ASSERT_CLK(a_accept_goes_busy, (start && !busy) |=> busy)
  `ASSERT_CLK(a_done_idle, done |-> !busy)
  `ASSERT_CLK(a_done_after_work, done |-> $past(busy))

endmodule

// ===== hdl/ffpra_dpath.sv =====
// Datapath for the page run allocator: page mark memory, walk index,
// run counter, region base register and result registers. Uses ffpra_pkg.
`include "first_fit_page_run_allocator_top_macros.svh"

module ffpra_dpath #(
  parameter int NUM_PAGES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data,
  input  logic                kind,
  input  logic [13:0]         page_count,
  input  logic [31:0]         address,
  input  ffpra_pkg::dp_cmd_t  cmd,
  output ffpra_pkg::dp_stat_t stat,
  output logic [1:0]          status,
  output logic [31:0]         run_address,
  output logic [12:0]         start_page
);
  import ffpra_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int XW = (CW > 14) ? CW : 14;
  localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

  logic [1:0]    mem [NUM_PAGES];
  logic [1:0]    rdata;
  logic          we;
  logic [PW-1:0] waddr;
  logic [1:0]    wdata;

  logic [31:0]   region_base;
  logic          kind_reg;
  logic [13:0]   n_reg;
  logic [19:0]   off_page;
  logic [31:0]   addr_off;
  logic [PW-1:0] idx, idx_d, first, end_idx, first_calc;
  logic [CW-1:0] run, run_inc;
  logic          rd_vld, last_issued, issue, is_free, hit;
  status_t       status_reg;

  assign addr_off   = address - region_base;
  assign issue      = (cmd.scan || cmd.free) && !last_issued;
  assign is_free    = (rdata == MARK_FREE);
  assign run_inc    = run + CW'(1);
  assign hit        = cmd.scan && rd_vld && is_free && (XW'(run_inc) == XW'(n_reg));
  assign first_calc = PW'(XW'(idx_d) + XW'(1) - XW'(n_reg));

  always_comb begin
    stat.clr_last  = (idx == LAST_PAGE);
    stat.bad       = (kind_reg == KIND_FREE) ? (off_page >= 20'(NUM_PAGES))
                                             : (n_reg == '0);
    stat.kind      = kind_reg;
    stat.hit       = hit;
    stat.miss      = cmd.scan && rd_vld && !hit && (idx_d == LAST_PAGE);
    stat.mark_last = (idx == end_idx);
    stat.free_stop = cmd.free && rd_vld && ((rdata == MARK_END) || (idx_d == LAST_PAGE));
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = MARK_FREE;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.mark) begin
      we    = 1'b1;
      wdata = (idx == end_idx) ? MARK_END : MARK_USED;
    end else if (cmd.free && rd_vld) begin
      we    = 1'b1;
      waddr = idx_d;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      idx         <= '0;
      rd_vld      <= 1'b0;
      last_issued <= 1'b0;
    end else begin
      if (cfg_write) begin
        region_base <= cfg_data;
      end
      rd_vld <= issue;
      if (cmd.begin_op) begin
        idx         <= (kind_reg == KIND_FREE) ? PW'(off_page) : '0;
        last_issued <= 1'b0;
      end else if (hit) begin
        // rewind to the run start for marking
        idx <= first_calc;
      end else if (cmd.clr || cmd.mark) begin
        idx <= idx + PW'(1);
      end else if (issue) begin
        if (idx == LAST_PAGE) begin
          last_issued <= 1'b1;
        end else begin
          idx <= idx + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (cmd.load) begin
      kind_reg <= kind;
      n_reg    <= page_count;
      off_page <= addr_off[31:PAGE_SHIFT];
    end
    if (cmd.begin_op) begin
      run   <= '0;
      first <= PW'(off_page);
    end else if (cmd.scan && rd_vld) begin
      run <= is_free ? run_inc : '0;
    end
    if (hit) begin
      first   <= first_calc;
      end_idx <= idx_d;
    end
    if (cmd.res_set) begin
      status_reg <= cmd.res_code;
      if (cmd.res_code == ST_OK) begin
        start_page  <= 13'(first);
        run_address <= (kind_reg == KIND_ALLOC) ? region_base + (32'(first) << PAGE_SHIFT)
                                                : '0;
      end else begin
        start_page  <= '0;
        run_address <= '0;
      end
    end
  end

  assign status = status_reg;

  `ASSERT_CLK(a_mark_in_run, cmd.mark |-> ((idx >= first) && (idx <= end_idx)))
  `ASSERT_CLK(a_hit_miss_excl, !(stat.hit && stat.miss))
  `ASSERT_CLK(a_read_from_walk, rd_vld |-> $past(cmd.scan || cmd.free))

endmodule

// ===== sim/first_fit_page_run_allocator_checker.sv =====
// Checker for the page run allocator: tracks the page table and region base,
// predicts one reply per request beat and compares it with each done beat.
// Depends on ffpra_pkg for status and mark codes.
`timescale 1ns / 1ps

module first_fit_page_run_allocator_checker #(
  parameter int NUM_PAGES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [13:0] page_count,
  input  logic [31:0] address,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] run_address,
  input  logic [12:0] start_page,
  output int          mismatches,
  output int          outstanding,
  output int          replies_checked
);
  import ffpra_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [31:0] addr;
    logic [12:0] page;
  } page_reply_t;

  mark_t       page_map [NUM_PAGES];
  logic [31:0] base_addr;
  page_reply_t pending_replies [$];
  page_reply_t want;
  int          fail_tally;
  int          checked_tally;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t ns: MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
             exp_val);
    fail_tally++;
  endtask

  // First fit from page 0; mark the run used and tag its last page.
  function automatic page_reply_t allocate_run(input int unsigned n);
    page_reply_t r;
    int unsigned run_len;
    int unsigned end_page;
    int unsigned first_page;
    logic        found;
    r.st = ST_BAD;
    r.addr = '0;
    r.page = '0;
    if (n == 0) return r;
    run_len = 0;
    found = 1'b0;
    end_page = 0;
    for (int unsigned i = 0; i < NUM_PAGES && !found; i++) begin
      if (page_map[i] == MARK_FREE) begin
        run_len++;
        if (run_len == n) begin
          found = 1'b1;
          end_page = i;
        end
      end else begin
        run_len = 0;
      end
    end
    if (!found) begin
      r.st = ST_NOROOM;
      return r;
    end
    first_page = end_page + 1 - n;
    for (int unsigned k = first_page; k < end_page; k++) page_map[k] = MARK_USED;
    page_map[end_page] = MARK_END;
    r.st = ST_OK;
    r.addr = base_addr + (32'(first_page) << PAGE_SHIFT);
    r.page = first_page[12:0];
    return r;
  endfunction

  // Clear from the addressed page through the next end tag or the table end.
  function automatic page_reply_t release_run(input logic [31:0] a);
    page_reply_t r;
    logic [31:0] off;
    int unsigned first_page;
    logic        hit_end;
    mark_t       m;
    r.st = ST_BAD;
    r.addr = '0;
    r.page = '0;
    off = a - base_addr;
    if (64'(off) >= (64'(NUM_PAGES) << PAGE_SHIFT)) return r;
    first_page = off >> PAGE_SHIFT;
    hit_end = 1'b0;
    for (int unsigned k = first_page; k < NUM_PAGES && !hit_end; k++) begin
      m = page_map[k];
      page_map[k] = MARK_FREE;
      if (m == MARK_END) hit_end = 1'b1;
    end
    r.st = ST_OK;
    r.page = first_page[12:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (page_map[i]) page_map[i] = MARK_FREE;
      base_addr = '0;
      pending_replies.delete();
    end else begin
      if (cfg_write) base_addr = cfg_data;
      // A done beat belongs to the previous request, so check before queuing.
      if (done) begin
        if (pending_replies.size() == 0) begin
          note_mismatch("reply with no request pending", 32'(status), 32'h0);
        end else begin
          want = pending_replies.pop_front();
          checked_tally++;
          if (status !== want.st) note_mismatch("status", 32'(status), 32'(want.st));
          if (run_address !== want.addr)
            note_mismatch("run_address", run_address, want.addr);
          if (start_page !== want.page)
            note_mismatch("start_page", 32'(start_page), 32'(want.page));
        end
      end
      if (start && !busy) begin
        if (kind == KIND_ALLOC) pending_replies.push_back(allocate_run(page_count));
        else pending_replies.push_back(release_run(address));
      end
    end
    mismatches <= fail_tally;
    outstanding <= pending_replies.size();
    replies_checked <= checked_tally;
  end

endmodule

// ===== sim/tb_first_fit_page_run_allocator_top.sv =====
// Testbench top for the page run allocator: clock, reset, request and
// region base stimulus, watchdog and verdict. Checking is done by
// first_fit_page_run_allocator_checker; codes come from ffpra_pkg.
`timescale 1ns / 1ps

module tb_first_fit_page_run_allocator_top;
  import ffpra_pkg::*;

  localparam int NUM_PAGES = 8192;
  localparam int IDLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 20;
  localparam int NUM_PHASES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        kind = KIND_ALLOC;
  logic [13:0] page_count = '0;
  logic [31:0] address = '0;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] run_address;
  logic [12:0] start_page;

  int          mismatches;
  int          outstanding;
  int          replies_checked;
  int          stall_cycles = 0;
  int          requests_sent = 0;
  int          burst_left = 1;
  logic [31:0] cur_base = '0;
  logic        last_kind = KIND_ALLOC;
  logic [12:0] live_pages [$];

  first_fit_page_run_allocator_top #(.NUM_PAGES(NUM_PAGES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .page_count(page_count), .address(address), .cfg_write(cfg_write),
    .cfg_data(cfg_data), .done(done), .status(status), .run_address(run_address),
    .start_page(start_page)
  );

  first_fit_page_run_allocator_checker #(.NUM_PAGES(NUM_PAGES)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .page_count(page_count), .address(address), .cfg_write(cfg_write),
    .cfg_data(cfg_data), .done(done), .status(status), .run_address(run_address),
    .start_page(start_page), .mismatches(mismatches), .outstanding(outstanding),
    .replies_checked(replies_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("first_fit_page_run_allocator_top test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Remember granted runs by page so later frees can target them.
  always @(posedge clk) begin
    if (done && last_kind == KIND_ALLOC && status == ST_OK) live_pages.push_back(start_page);
    if (start && !busy) last_kind <= kind;
  end

  task automatic issue(input logic k, input logic [13:0] n, input logic [31:0] a);
    start <= 1'b1;
    kind <= k;
    page_count <= n;
    address <= a;
    do @(posedge clk); while (busy);
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 6);
    end
  endtask

  task automatic request_run(input logic [13:0] n);
    issue(KIND_ALLOC, n, $urandom);
  endtask

  task automatic free_at(input logic [31:0] a);
    issue(KIND_FREE, 14'($urandom), a);
  endtask

  function automatic logic [31:0] page_addr(input int unsigned pg, input logic [11:0] off);
    return cur_base + {7'd0, pg[12:0], off};
  endfunction

  // Hold until every reply is in and the block is idle, then write the base.
  task automatic set_region_base(input logic [31:0] b);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    cfg_write <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_base = b;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned idx;
    logic [11:0] off;
    pick = $urandom_range(0, 99);
    off = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0;
    if (pick < 40) begin
      request_run(14'($urandom_range(1, 12)));
    end else if (pick < 44) begin
      request_run(14'($urandom_range(13, 400)));
    end else if (pick < 46) begin
      request_run($urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(NUM_PAGES + 1, 16383)));
    end else if (pick < 80) begin
      if (live_pages.size() == 0) begin
        request_run(14'($urandom_range(1, 12)));
      end else begin
        idx = $urandom_range(0, live_pages.size() - 1);
        free_at(page_addr(live_pages[idx], off));
        live_pages.delete(idx);
      end
    end else if (pick < 90) begin
      free_at(page_addr($urandom_range(0, NUM_PAGES - 1), 12'($urandom)));
    end else begin
      free_at($urandom);
    end
  endtask

  task automatic directed_requests();
    request_run(14'd0);                      // zero count
    request_run(14'h3FFF);                   // far beyond the table
    request_run(14'(NUM_PAGES + 1));
    request_run(14'(NUM_PAGES));             // whole table
    request_run(14'd1);                      // table full
    free_at(page_addr(0, 12'd0));
    request_run(14'(NUM_PAGES - 1));
    request_run(14'd1);                      // lands on the last page
    free_at(page_addr(NUM_PAGES - 1, 12'd0));
    free_at(cur_base + (32'(NUM_PAGES) << PAGE_SHIFT)); // one past the region
    free_at(cur_base - 32'd1);               // below the region
    free_at(page_addr(NUM_PAGES - 1, 12'hFFF));
    free_at(page_addr(0, 12'hFFF));          // unaligned
    request_run(14'd1);
    request_run(14'd3);
    request_run(14'd2);
    free_at(page_addr(1, 12'd0));
    request_run(14'd2);                      // refill the hole first fit
    request_run(14'd4);                      // hole too small, goes past it
    free_at(page_addr(7, 12'd0));            // middle of a run
    free_at(page_addr(5, 12'd0));
    free_at(page_addr(4000, 12'h800));       // no end tag ahead: clear to the end
  endtask

  initial begin
    logic [31:0] next_base;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: next_base = 32'h0;
        1: next_base = 32'hFFFF_F000;           // run addresses wrap
        2: next_base = {20'($urandom_range(0, 32'hF_FFFF)), 12'h0};
        default: next_base = 32'hFFFF_FFFF;     // unaligned base
      endcase
      set_region_base(next_base);
      if (ph == 0) directed_requests();
      repeat (RANDOM_PER_PHASE) random_request();
    end
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests across %0d region base settings; %0d replies checked.",
             requests_sent, NUM_PHASES, replies_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("first_fit_page_run_allocator_top test passed");
    end else begin
      $display("first_fit_page_run_allocator_top test failed");
    end
    $finish;
  end

endmodule
